// File: hw/rtl/segment_intersection_core_assert.svh
// ----------------------------------------------------------------------------
// Segment intersection core assertion macros
// Shared concurrent assertion forms, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_CORE_ASSERT_SVH
`define SEGMENT_INTERSECTION_CORE_ASSERT_SVH

// Check outside reset.
`define SIC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check at every edge, reset included.
`define SIC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/sic_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection package
// Shared constants for the segment intersection core.
// ----------------------------------------------------------------------------
package sic_pkg;

  // Default coordinate width
  localparam int unsigned CoordWidthDef = 16;

endpackage

// File: hw/rtl/sic_front.sv
// ----------------------------------------------------------------------------
// Segment intersection front end
// Four stages: differences, cross products, determinant and range test,
// numerator magnitudes. Feeds the divider cell chain.
// ----------------------------------------------------------------------------
module sic_front #(
  parameter int unsigned CoordWidth = sic_pkg::CoordWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                ce_i,
  input  logic                                valid_i,
  input  logic [8*CoordWidth-1:0]             coord_i,
  output logic                                valid_o,
  output logic                                hit_o,
  output logic [1:0]                          sign_o,
  output logic [1:0][CoordWidth-1:0]          bs_o,
  output logic [2*CoordWidth:0]               dmag_o,
  output logic [1:0][3*CoordWidth:0]          nmag_o
);
  import sic_pkg::*;

  localparam int unsigned W  = CoordWidth;
  localparam int unsigned D  = W + 1;
  localparam int unsigned P  = 2 * W + 2;
  localparam int unsigned MW = 2 * W + 1;
  localparam int unsigned NW = 3 * W + 1;

  logic signed [W-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
  assign x1 = coord_i[0*W +: W];
  assign y1 = coord_i[1*W +: W];
  assign x2 = coord_i[2*W +: W];
  assign y2 = coord_i[3*W +: W];
  assign x3 = coord_i[4*W +: W];
  assign y3 = coord_i[5*W +: W];
  assign x4 = coord_i[6*W +: W];
  assign y4 = coord_i[7*W +: W];

  // Stage 1: differences
  logic v1_q;
  logic signed [D-1:0] dax_q, day_q, dbx_q, dby_q, dcx_q, dcy_q, ex1_q, ey1_q;
  logic [W-1:0] bsx1_q, bsy1_q;

  // Stage 2: products
  logic v2_q;
  logic signed [P-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [D-1:0] ex2_q, ey2_q;
  logic [W-1:0] bsx2_q, bsy2_q;

  // Stage 3: determinant, range test, magnitudes
  logic v3_q, hit3_q;
  logic [1:0] sign3_q;
  logic [MW-1:0] umag_q, dmag3_q;
  logic [W-1:0] exm_q, eym_q, bsx3_q, bsy3_q;

  // Stage 4: numerator products
  logic v4_q, hit4_q;
  logic [1:0] sign4_q;
  logic [MW-1:0] dmag4_q;
  logic [NW-1:0] nx_q, ny_q;
  logic [W-1:0] bsx4_q, bsy4_q;

  logic signed [P-1:0] den_d, tn_d, un_d;
  logic t_ok_d, u_ok_d, hit_d;
  logic [P-1:0] uabs_d, dabs_d;
  logic [D-1:0] exa_d, eya_d;

  always_comb begin
    den_d = p0_q - p1_q;
    tn_d  = p2_q - p3_q;
    un_d  = p5_q - p4_q;
    if (den_d[P-1]) begin
      t_ok_d = (den_d <= tn_d) && (tn_d <= 0);
      u_ok_d = (den_d <= un_d) && (un_d <= 0);
    end else begin
      t_ok_d = (tn_d >= 0) && (tn_d <= den_d);
      u_ok_d = (un_d >= 0) && (un_d <= den_d);
    end
    hit_d  = (den_d != '0) && t_ok_d && u_ok_d;
    uabs_d = un_d[P-1] ? -un_d : un_d;
    dabs_d = den_d[P-1] ? -den_d : den_d;
    exa_d  = ex2_q[D-1] ? -ex2_q : ex2_q;
    eya_d  = ey2_q[D-1] ? -ey2_q : ey2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (ce_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      dax_q  <= D'(x1) - D'(x2);
      day_q  <= D'(y1) - D'(y2);
      dbx_q  <= D'(x3) - D'(x4);
      dby_q  <= D'(y3) - D'(y4);
      dcx_q  <= D'(x1) - D'(x3);
      dcy_q  <= D'(y1) - D'(y3);
      ex1_q  <= D'(x4) - D'(x3);
      ey1_q  <= D'(y4) - D'(y3);
      bsx1_q <= x3;
      bsy1_q <= y3;

      p0_q   <= dax_q * dby_q;
      p1_q   <= day_q * dbx_q;
      p2_q   <= dcx_q * dby_q;
      p3_q   <= dcy_q * dbx_q;
      p4_q   <= dax_q * dcy_q;
      p5_q   <= day_q * dcx_q;
      ex2_q  <= ex1_q;
      ey2_q  <= ey1_q;
      bsx2_q <= bsx1_q;
      bsy2_q <= bsy1_q;

      hit3_q  <= hit_d;
      // Zero numerator on a miss so the quotient settles to zero
      umag_q  <= hit_d ? uabs_d[MW-1:0] : '0;
      dmag3_q <= hit_d ? dabs_d[MW-1:0] : {{(MW-1){1'b0}}, 1'b1};
      exm_q   <= exa_d[W-1:0];
      eym_q   <= eya_d[W-1:0];
      sign3_q <= {un_d[P-1] ^ ey2_q[D-1] ^ den_d[P-1],
                  un_d[P-1] ^ ex2_q[D-1] ^ den_d[P-1]};
      bsx3_q  <= bsx2_q;
      bsy3_q  <= bsy2_q;

      hit4_q  <= hit3_q;
      sign4_q <= sign3_q;
      dmag4_q <= dmag3_q;
      nx_q    <= NW'(umag_q) * NW'(exm_q);
      ny_q    <= NW'(umag_q) * NW'(eym_q);
      bsx4_q  <= bsx3_q;
      bsy4_q  <= bsy3_q;
    end
  end

  assign valid_o = v4_q;
  assign hit_o   = hit4_q;
  assign sign_o  = sign4_q;
  assign bs_o    = {bsy4_q, bsx4_q};
  assign dmag_o  = dmag4_q;
  assign nmag_o  = {ny_q, nx_q};

endmodule

// File: hw/rtl/sic_div_cell.sv
// ----------------------------------------------------------------------------
// Segment intersection divider cell
// One restoring division step for both axes; passes the beat to the next cell.
// ----------------------------------------------------------------------------
module sic_div_cell #(
  parameter int unsigned CoordWidth = sic_pkg::CoordWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              ce_i,
  input  logic                              valid_i,
  input  logic                              hit_i,
  input  logic [1:0]                        sign_i,
  input  logic [1:0][CoordWidth-1:0]        bs_i,
  input  logic [2*CoordWidth:0]             dmag_i,
  input  logic [1:0][2*CoordWidth:0]        rem_i,
  input  logic [1:0][CoordWidth-1:0]        nlo_i,
  input  logic [1:0][CoordWidth-1:0]        quo_i,
  output logic                              valid_o,
  output logic                              hit_o,
  output logic [1:0]                        sign_o,
  output logic [1:0][CoordWidth-1:0]        bs_o,
  output logic [2*CoordWidth:0]             dmag_o,
  output logic [1:0][2*CoordWidth:0]        rem_o,
  output logic [1:0][CoordWidth-1:0]        nlo_o,
  output logic [1:0][CoordWidth-1:0]        quo_o
);
  import sic_pkg::*;

  localparam int unsigned W  = CoordWidth;
  localparam int unsigned MW = 2 * W + 1;

  logic                  valid_q, hit_q;
  logic [1:0]            sign_q;
  logic [1:0][W-1:0]     bs_q, nlo_q, quo_q;
  logic [MW-1:0]         dmag_q;
  logic [1:0][MW-1:0]    rem_q;

  logic [1:0][MW:0]      trial;
  logic [1:0]            ge;
  logic [1:0][MW-1:0]    rem_d;
  logic [1:0][W-1:0]     quo_d;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      trial[a] = {rem_i[a], nlo_i[a][W-1]};
      ge[a]    = trial[a] >= {1'b0, dmag_i};
      rem_d[a] = ge[a] ? MW'(trial[a] - {1'b0, dmag_i}) : trial[a][MW-1:0];
      quo_d[a] = {quo_i[a][W-2:0], ge[a]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ce_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      hit_q  <= hit_i;
      sign_q <= sign_i;
      bs_q   <= bs_i;
      dmag_q <= dmag_i;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      nlo_q  <= {nlo_i[1] << 1, nlo_i[0] << 1};
    end
  end

  assign valid_o = valid_q;
  assign hit_o   = hit_q;
  assign sign_o  = sign_q;
  assign bs_o    = bs_q;
  assign dmag_o  = dmag_q;
  assign rem_o   = rem_q;
  assign nlo_o   = nlo_q;
  assign quo_o   = quo_q;

endmodule

// File: hw/rtl/segment_intersection_core.sv
// Throughput: one segment pair per cycle when not stalled; the division runs down a chain
// of CoordWidth cells, one quotient bit per cell, and every stage moves together.
// Backpressure on the output stalls the whole pipeline in place.
// Reset clears all valid flags; payload registers keep whatever they hold.
// ----------------------------------------------------------------------------
// Segment intersection core
// Determinant test of two segments and the crossing point on segment B.
// ----------------------------------------------------------------------------
module segment_intersection_core #(
  parameter int unsigned CoordWidth = sic_pkg::CoordWidthDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [8*CoordWidth-1:0]                 s_axis_tdata_i,
  output logic                                    m_axis_tvalid_o,
  input  logic                                    m_axis_tready_i,
  // cross_x, cross_y, zero padding
  output logic [((2*CoordWidth+7)/8)*8-1:0]       m_axis_tdata_o,
  // hit
  output logic                                    m_axis_tuser_o
);
  import sic_pkg::*;

  `include "segment_intersection_core_assert.svh"

  localparam int unsigned W  = CoordWidth;
  localparam int unsigned MW = 2 * W + 1;
  localparam int unsigned NW = 3 * W + 1;
  localparam int unsigned OW = ((2 * W + 7) / 8) * 8;

  logic ce;
  logic out_valid_q, out_hit_q;
  logic [W-1:0] out_x_q, out_y_q;

  // Hold every stage while the output beat waits
  assign ce = !(out_valid_q && !m_axis_tready_i);
  assign s_axis_tready_o = ce;

  logic                   f_valid, f_hit;
  logic [1:0]             f_sign;
  logic [1:0][W-1:0]      f_bs;
  logic [MW-1:0]          f_dmag;
  logic [1:0][NW-1:0]     f_nmag;

  sic_front #(.CoordWidth(W)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ce_i    (ce),
    .valid_i (s_axis_tvalid_i),
    .coord_i (s_axis_tdata_i),
    .valid_o (f_valid),
    .hit_o   (f_hit),
    .sign_o  (f_sign),
    .bs_o    (f_bs),
    .dmag_o  (f_dmag),
    .nmag_o  (f_nmag)
  );

  logic [W:0]                   c_valid, c_hit;
  logic [W:0][1:0]              c_sign;
  logic [W:0][1:0][W-1:0]       c_bs, c_nlo, c_quo;
  logic [W:0][MW-1:0]           c_dmag;
  logic [W:0][1:0][MW-1:0]      c_rem;

  assign c_valid[0] = f_valid;
  assign c_hit[0]   = f_hit;
  assign c_sign[0]  = f_sign;
  assign c_bs[0]    = f_bs;
  assign c_dmag[0]  = f_dmag;
  assign c_rem[0]   = {f_nmag[1][NW-1:W], f_nmag[0][NW-1:W]};
  assign c_nlo[0]   = {f_nmag[1][W-1:0], f_nmag[0][W-1:0]};
  assign c_quo[0]   = '0;

  for (genvar i = 0; i < W; i++) begin : g_cell
    sic_div_cell #(.CoordWidth(W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ce_i    (ce),
      .valid_i (c_valid[i]),
      .hit_i   (c_hit[i]),
      .sign_i  (c_sign[i]),
      .bs_i    (c_bs[i]),
      .dmag_i  (c_dmag[i]),
      .rem_i   (c_rem[i]),
      .nlo_i   (c_nlo[i]),
      .quo_i   (c_quo[i]),
      .valid_o (c_valid[i+1]),
      .hit_o   (c_hit[i+1]),
      .sign_o  (c_sign[i+1]),
      .bs_o    (c_bs[i+1]),
      .dmag_o  (c_dmag[i+1]),
      .rem_o   (c_rem[i+1]),
      .nlo_o   (c_nlo[i+1]),
      .quo_o   (c_quo[i+1])
    );
  end

  logic [W-1:0] qx, qy;
  assign qx = c_sign[W][0] ? (~c_quo[W][0] + 1'b1) : c_quo[W][0];
  assign qy = c_sign[W][1] ? (~c_quo[W][1] + 1'b1) : c_quo[W][1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ce) begin
      out_valid_q <= c_valid[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      out_hit_q <= c_hit[W];
      out_x_q   <= c_hit[W] ? c_bs[W][0] + qx : '0;
      out_y_q   <= c_hit[W] ? c_bs[W][1] + qy : '0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OW'({out_y_q, out_x_q});
  assign m_axis_tuser_o  = out_hit_q;

  `SIC_ASSERT(a_miss_zero, (out_valid_q && !out_hit_q) |-> (m_axis_tdata_o == '0), "miss with point")
  `SIC_ASSERT(a_ready_stall, s_axis_tready_o == !(out_valid_q && !m_axis_tready_i), "bad ready")
  `SIC_ASSERT(a_hold_stall, (out_valid_q && !m_axis_tready_i) |=> (out_valid_q && $stable(c_valid)), "moved")
  `SIC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !m_axis_tvalid_o, "output valid during reset")

endmodule

// File: tb/segment_intersection_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection core testbench
// Drives segment pairs through the input stream under several idle and stall
// patterns, predicts hit and crossing point with exact integer arithmetic and
// compares every output beat in order against the predicted queue.
// ----------------------------------------------------------------------------
module segment_intersection_core_tb;

  localparam int CW = sic_pkg::CoordWidthDef;
  localparam int OW = ((2*CW+7)/8)*8;

  typedef struct packed {
    logic          hit;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
  } crossing_t;

  class crossing_scoreboard;
    crossing_t pending_q[$];
    int        errors;

    function longint crd(logic [8*CW-1:0] d, int idx);
      logic signed [CW-1:0] v;
      v = d[idx*CW +: CW];
      return longint'(v);
    endfunction

    function bit in_unit(longint num, longint den);
      if (den < 0) return (den <= num) && (num <= 0);
      return (num >= 0) && (num <= den);
    endfunction

    // Note an accepted pair and queue its predicted crossing.
    function void note_pair(logic [8*CW-1:0] d);
      longint x1, y1, x2, y2, x3, y3, x4, y4, den, tn, un;
      crossing_t e;
      x1 = crd(d, 0); y1 = crd(d, 1); x2 = crd(d, 2); y2 = crd(d, 3);
      x3 = crd(d, 4); y3 = crd(d, 5); x4 = crd(d, 6); y4 = crd(d, 7);
      e = '0;
      den = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
      tn  = (x1 - x3) * (y3 - y4) - (y1 - y3) * (x3 - x4);
      un  = -((x1 - x2) * (y1 - y3) - (y1 - y2) * (x1 - x3));
      if (den != 0 && in_unit(tn, den) && in_unit(un, den)) begin
        e.hit = 1'b1;
        e.cx  = CW'(x3 + (un * (x4 - x3)) / den);
        e.cy  = CW'(y3 + (un * (y4 - y3)) / den);
      end
      pending_q.push_back(e);
    endfunction

    function void check_crossing(logic [OW-1:0] d, logic u);
      crossing_t a, e;
      a.hit = u;
      a.cx  = d[CW-1:0];
      a.cy  = d[2*CW-1:CW];
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $time, a);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (a.hit !== e.hit) begin
        $display("%0t: hit expected %0b actual %0b", $time, e.hit, a.hit);
        errors++;
      end
      if (a.cx !== e.cx) begin
        $display("%0t: cross_x expected %h actual %h", $time, e.cx, a.cx);
        errors++;
      end
      if (a.cy !== e.cy) begin
        $display("%0t: cross_y expected %h actual %h", $time, e.cy, a.cy);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [8*CW-1:0]   s_axis_tdata_i = '0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [OW-1:0]     m_axis_tdata_o;
  logic              m_axis_tuser_o;

  crossing_scoreboard sb = new();
  int  idle_pct  = 0;
  int  stall_pct = 0;
  bit  hold_req  = 1'b0;

  segment_intersection_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int hold_cnt;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        hold_cnt++;
        if (hold_cnt >= 200) begin
          hold_req = 1'b0;
          hold_cnt = 0;
        end
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Output monitor: sample at the falling edge, take the beat at the rising one.
  initial begin
    bit            take;
    logic [OW-1:0] d;
    logic          u;
    forever begin
      @(negedge clk_i);
      take = m_axis_tvalid_o && m_axis_tready_i && rst_ni;
      d    = m_axis_tdata_o;
      u    = m_axis_tuser_o;
      @(posedge clk_i);
      if (take) sb.check_crossing(d, u);
    end
  end

  task automatic send_pair(logic [8*CW-1:0] d);
    bit rdy;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= d;
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready_o;
      @(posedge clk_i);
    end while (!rdy);
    sb.note_pair(d);
  endtask

  function automatic logic [8*CW-1:0] pack8(longint p[8]);
    logic [8*CW-1:0] d;
    for (int i = 0; i < 8; i++) d[i*CW +: CW] = CW'(p[i]);
    return d;
  endfunction

  function automatic longint rnd_full();
    return longint'($urandom_range(65535)) - 32768;
  endfunction

  function automatic longint near(longint c, int r);
    return c + longint'($urandom_range(2*r)) - r;
  endfunction

  // Mostly local pairs that often cross, with parallel, touching and noise cases.
  function automatic logic [8*CW-1:0] random_pair();
    longint p[8];
    longint cx, cy, dx, dy, k;
    int r, ja, jb;
    r  = $urandom_range(3, 300);
    cx = longint'($urandom_range(60000)) - 30000;
    cy = longint'($urandom_range(60000)) - 30000;
    case ($urandom_range(9))
      0, 1: for (int i = 0; i < 8; i++) p[i] = rnd_full();
      2: begin
        // parallel or collinear: B is A shifted
        dx = near(0, r); dy = near(0, r);
        p[0] = cx; p[1] = cy; p[2] = cx + dx; p[3] = cy + dy;
        k = $urandom_range(1) ? 0 : near(0, 20);
        p[4] = cx + dx/2 + k; p[5] = cy + dy/2 - k; p[6] = p[4] + dx; p[7] = p[5] + dy;
        if (k == 0) begin p[4] = cx + dx; p[5] = cy + dy; end
      end
      3: begin
        // shared endpoint
        for (int i = 0; i < 8; i += 2) begin p[i] = near(cx, r); p[i+1] = near(cy, r); end
        ja = 2 * int'($urandom_range(1));
        jb = 4 + 2 * int'($urandom_range(1));
        p[jb]   = p[ja];
        p[jb+1] = p[ja+1];
      end
      default:
        for (int i = 0; i < 8; i += 2) begin p[i] = near(cx, r); p[i+1] = near(cy, r); end
    endcase
    return pack8(p);
  endfunction

  task automatic drain(int tail);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  initial begin
    longint lo = -32768, hi = 32767;
    longint dir[20][8];
    dir = '{
      '{lo, lo, hi, hi, lo, hi, hi, lo},     // full-range diagonals
      '{hi, lo, lo, hi, lo, lo, hi, hi},
      '{lo, lo, lo, lo, hi, hi, hi, hi},     // corners, degenerate
      '{hi, hi, hi, hi, hi, hi, hi, hi},
      '{lo, 0, hi, 0, 0, lo, 0, hi},         // axis cross at origin
      '{0, 0, 10, 0, 0, 5, 10, 5},           // parallel
      '{0, 0, 10, 0, 5, 0, 20, 0},           // collinear overlap
      '{3, 3, 3, 3, 0, 0, 9, 9},             // degenerate A on B
      '{0, 0, 10, 10, 0, 0, 10, 0},          // touching at start points
      '{0, 0, 10, 10, 10, 10, 20, 0},        // end meets start
      '{0, 0, 10, 0, 5, 0, 5, 10},           // t inside, u zero
      '{0, 0, 10, 0, 5, 10, 5, 0},           // u exactly one
      '{0, 0, 10, 0, 10, -5, 10, 5},         // t exactly one
      '{0, 0, 10, 0, 11, -5, 11, 5},         // just past A
      '{0, 0, 10, 0, 5, 1, 5, 10},           // just short of A
      '{0, 0, 7, 3, 1, 5, 6, -4},            // inexact quotient, truncation
      '{0, 0, -7, -3, -1, -5, -6, 4},
      '{hi, lo, lo, hi, hi, hi, lo, lo},
      '{-1, -1, 1, 1, -1, 1, 1, -1},
      '{lo, hi, lo, lo, hi, 0, lo, 0}
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir[i]) send_pair(pack8(dir[i]));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct <= 0;  stall_pct <= 0;  end
        1: begin idle_pct <= 79; stall_pct <= 0;  end
        2: begin idle_pct <= 0;  stall_pct <= 79; end
        default: begin idle_pct <= 29; stall_pct <= 29; end
      endcase
      for (int n = 0; n < 160; n++) begin
        if (ph == 0 && n == 40) hold_req = 1'b1;
        if (n == 80 && ph == 1) begin
          s_axis_tvalid_i <= 1'b0;
          drain(0);
        end
        send_pair(random_pair());
      end
    end
    s_axis_tvalid_i <= 1'b0;
    drain(40);

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/sic_pkg.sv
hw/rtl/sic_front.sv
hw/rtl/sic_div_cell.sv
hw/rtl/segment_intersection_core.sv
tb/segment_intersection_core_tb.sv
